// ----- rtl/teq_pkg.sv -----
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants of the timed event queue
// Entry pool sizes, action and status codes, channel item structs and the
// store port structs.
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 16;
   localparam int MAX_RESULTS = 16;
   localparam int TIME_W      = 32;
   localparam int DELAY_W     = 31;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   // pointer holds an entry index or the empty marker
   localparam int PTR_W       = IDX_W + 1;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [PTR_W-1:0] EMPTY_MARK = PTR_W'(QUEUE_DEPTH);

   // action codes
   localparam logic [1:0] ACT_SCHEDULE = 2'd0;
   localparam logic [1:0] ACT_CANCEL   = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;

   // status codes
   localparam logic [2:0] STAT_SCHEDULED = 3'd0;
   localparam logic [2:0] STAT_FULL      = 3'd1;
   localparam logic [2:0] STAT_REMOVED   = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [2:0] STAT_DUE       = 3'd4;
   localparam logic [2:0] STAT_NONE_DUE  = 3'd5;

   typedef struct packed {
      logic [1:0]          action;
      logic [TAG_BITS-1:0] event_tag;
      logic [DELAY_W-1:0]  delay;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [TAG_BITS-1:0] due_tag;
      logic                last;
   } rsp_type;

   // write side of the entry store
   typedef struct packed {
      logic                due_we;
      logic [IDX_W-1:0]    due_idx;
      logic [TIME_W-1:0]   due_data;
      logic [TAG_BITS-1:0] tag_data;
      logic                na_we;
      logic [IDX_W-1:0]    na_idx;
      logic [PTR_W-1:0]    na_data;
      logic                nb_we;
      logic [IDX_W-1:0]    nb_idx;
      logic [PTR_W-1:0]    nb_data;
   } st_wr_type;

   // one entry as read from the store
   typedef struct packed {
      logic [TIME_W-1:0]   due;
      logic [TAG_BITS-1:0] tag;
      logic [PTR_W-1:0]    nxt;
   } st_rd_type;

   // compare unit results
   typedef struct packed {
      logic not_after;
      logic tag_eq;
   } cmp_type;

   // pointer refers to a real entry
   function automatic logic idx_ok(input logic [PTR_W-1:0] p);
      return p < PTR_W'(QUEUE_DEPTH);
   endfunction

endpackage

// ----- rtl/teq_store.sv -----
// ----------------------------------------------------------------------------
// teq_store: entry pool register file
// Due time, tag and link per entry. One read address per cycle, one
// due/tag write and two link writes per cycle.
// ----------------------------------------------------------------------------
module teq_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [teq_pkg::IDX_W-1:0] rd_idx,
   input  teq_pkg::st_wr_type        wr,
   output teq_pkg::st_rd_type        rd
);
   import teq_pkg::*;

   logic [TIME_W-1:0]   due_ff  [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] tag_ff  [QUEUE_DEPTH];
   logic [PTR_W-1:0]    next_ff [QUEUE_DEPTH];

   // due time and tag: no reset, written before first read
   always_ff @(posedge clock) begin
      if (wr.due_we) begin
         due_ff[wr.due_idx] <= wr.due_data;
         tag_ff[wr.due_idx] <= wr.tag_data;
      end
   end

   // links: reset chains the whole pool into the free list
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_next
      always_ff @(posedge clock) begin
         if (reset) begin
            next_ff[i] <= PTR_W'(i + 1);
         end else if (wr.na_we && wr.na_idx == IDX_W'(i)) begin
            next_ff[i] <= wr.na_data;
         end else if (wr.nb_we && wr.nb_idx == IDX_W'(i)) begin
            next_ff[i] <= wr.nb_data;
         end
      end
   end

   // read port
   assign rd.due = due_ff[rd_idx];
   assign rd.tag = tag_ff[rd_idx];
   assign rd.nxt = next_ff[rd_idx];

endmodule

// ----- rtl/teq_cmp.sv -----
// ----------------------------------------------------------------------------
// teq_cmp: shared compare unit
// Wrap-safe due-time compare by signed 32-bit difference, and tag match.
// ----------------------------------------------------------------------------
module teq_cmp (
   input  teq_pkg::st_rd_type          rd,
   input  logic [teq_pkg::TIME_W-1:0]  key,
   output teq_pkg::cmp_type            res
);
   import teq_pkg::*;

   logic [TIME_W-1:0] diff;

   // entry due at or before key
   assign diff          = rd.due - key;
   assign res.not_after = (diff == '0) || diff[TIME_W-1];
   assign res.tag_eq    = (rd.tag == key[TAG_BITS-1:0]);

endmodule

// ----- rtl/timed_event_queue_core.sv -----
// ----------------------------------------------------------------------------
// timed_event_queue_core: sorted timer event queue
// Fixed pool of timed events in a linked list sorted by due time, with a
// free list. Schedule, cancel and one-microsecond tick commands.
//
//   channel | direction | ports                          | item
//   req     | in        | req_valid req_ready req_data   | action, tag, delay
//   rsp     | out       | rsp_valid rsp_ready rsp_data   | status, tag, last
//
// A command is taken in idle and walks the list, a schedule on a full pool
// excepted; one list entry per cycle through the single store read port and
// the shared compare unit, in a tick walk only while rsp is free.
// Reset: synchronous; empty queue, counter zero, whole pool on free list.
// A stalled rsp holds the walk at its next result; req is taken only when
// the sequencer is idle, even while a result still waits in rsp.
// ----------------------------------------------------------------------------
module timed_event_queue_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  teq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output teq_pkg::rsp_type rsp_data
);
   import teq_pkg::*;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_SCHED,
      SQ_CANCEL,
      SQ_TICK,
      SQ_EMIT
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] key_ff, key_in;
   logic [PTR_W-1:0]  qhead_ff, qhead_in;
   logic [PTR_W-1:0]  fhead_ff, fhead_in;
   logic [PTR_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  prev_ff, prev_in;
   logic [PTR_W-1:0]  cur_ff, cur_in;
   logic [PTR_W-1:0]  node_ff, node_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   rsp_type           pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              push;
   rsp_type           push_data;
   logic              out_free;
   logic [TIME_W-1:0] due_sum;
   logic [PTR_W-1:0]  rd_ptr;
   st_wr_type         wr;
   st_rd_type         rd;
   cmp_type           cmp;

   // entry storage and compare unit
   teq_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (rd_ptr[IDX_W-1:0]),
      .wr     (wr),
      .rd     (rd)
   );

   teq_cmp u_cmp (
      .rd  (rd),
      .key (key_ff),
      .res (cmp)
   );

   // read address follows the walk
   always_comb begin
      case (state_ff)
         SQ_IDLE:   rd_ptr = fhead_ff;
         SQ_SCHED:  rd_ptr = cur_ff;
         SQ_CANCEL: rd_ptr = cur_ff;
         SQ_TICK:   rd_ptr = qhead_ff;
         default:   rd_ptr = fhead_ff;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == SQ_IDLE);
   assign due_sum   = now_ff + TIME_W'(req_data.delay);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      key_in        = key_ff;
      qhead_in      = qhead_ff;
      fhead_in      = fhead_ff;
      count_in      = count_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      node_in       = node_ff;
      k_in          = k_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      wr            = '0;
      push          = 1'b0;
      push_data     = pend_ff;

      case (state_ff)
         SQ_IDLE: begin
            if (req_valid) begin
               case (req_data.action)
                  ACT_SCHEDULE: begin
                     if (!idx_ok(fhead_ff)) begin
                        pend_in  = '{status: STAT_FULL, due_tag: '0, last: 1'b1};
                        state_in = SQ_EMIT;
                     end else begin
                        // take the free head and store the new entry
                        wr.due_we   = 1'b1;
                        wr.due_idx  = fhead_ff[IDX_W-1:0];
                        wr.due_data = due_sum;
                        wr.tag_data = req_data.event_tag;
                        fhead_in    = rd.nxt;
                        node_in     = fhead_ff;
                        key_in      = due_sum;
                        prev_in     = EMPTY_MARK;
                        cur_in      = qhead_ff;
                        state_in    = SQ_SCHED;
                     end
                  end
                  ACT_CANCEL: begin
                     key_in   = TIME_W'(req_data.event_tag);
                     prev_in  = EMPTY_MARK;
                     cur_in   = qhead_ff;
                     state_in = SQ_CANCEL;
                  end
                  ACT_TICK: begin
                     now_in        = now_ff + TIME_W'(1);
                     key_in        = now_ff + TIME_W'(1);
                     k_in          = '0;
                     pend_valid_in = 1'b0;
                     state_in      = SQ_TICK;
                  end
                  default: ;
               endcase
            end
         end

         SQ_SCHED: begin
            if (idx_ok(cur_ff) && cmp.not_after) begin
               prev_in = cur_ff;
               cur_in  = rd.nxt;
            end else begin
               // link the new entry between prev and cur
               wr.na_we   = 1'b1;
               wr.na_idx  = node_ff[IDX_W-1:0];
               wr.na_data = cur_ff;
               if (idx_ok(prev_ff)) begin
                  wr.nb_we   = 1'b1;
                  wr.nb_idx  = prev_ff[IDX_W-1:0];
                  wr.nb_data = node_ff;
               end else begin
                  qhead_in = node_ff;
               end
               count_in = count_ff + PTR_W'(1);
               pend_in  = '{status: STAT_SCHEDULED, due_tag: '0, last: 1'b1};
               state_in = SQ_EMIT;
            end
         end

         SQ_CANCEL: begin
            if (!idx_ok(cur_ff)) begin
               pend_in  = '{status: STAT_NOT_FOUND, due_tag: '0, last: 1'b1};
               state_in = SQ_EMIT;
            end else if (cmp.tag_eq) begin
               // unlink cur and return it to the free list
               if (idx_ok(prev_ff)) begin
                  wr.na_we   = 1'b1;
                  wr.na_idx  = prev_ff[IDX_W-1:0];
                  wr.na_data = rd.nxt;
               end else begin
                  qhead_in = rd.nxt;
               end
               wr.nb_we   = 1'b1;
               wr.nb_idx  = cur_ff[IDX_W-1:0];
               wr.nb_data = fhead_ff;
               fhead_in   = cur_ff;
               if (count_ff != '0) begin
                  count_in = count_ff - PTR_W'(1);
               end
               pend_in  = '{status: STAT_REMOVED, due_tag: '0, last: 1'b1};
               state_in = SQ_EMIT;
            end else begin
               prev_in = cur_ff;
               cur_in  = rd.nxt;
            end
         end

         SQ_TICK: begin
            if (out_free) begin
               if (k_ff < CNT_W'(MAX_RESULTS) && idx_ok(qhead_ff) && cmp.not_after) begin
                  // release head; previous release goes out as not last
                  if (pend_valid_ff) begin
                     push = 1'b1;
                  end
                  pend_in       = '{status: STAT_DUE, due_tag: rd.tag, last: 1'b0};
                  pend_valid_in = 1'b1;
                  qhead_in      = rd.nxt;
                  wr.na_we      = 1'b1;
                  wr.na_idx     = qhead_ff[IDX_W-1:0];
                  wr.na_data    = fhead_ff;
                  fhead_in      = qhead_ff;
                  if (count_ff != '0) begin
                     count_in = count_ff - PTR_W'(1);
                  end
                  k_in = k_ff + CNT_W'(1);
               end else begin
                  push = 1'b1;
                  if (pend_valid_ff) begin
                     push_data = '{status: STAT_DUE, due_tag: pend_ff.due_tag, last: 1'b1};
                  end else begin
                     push_data = '{status: STAT_NONE_DUE, due_tag: '0, last: 1'b1};
                  end
                  pend_valid_in = 1'b0;
                  state_in      = SQ_IDLE;
               end
            end
         end

         SQ_EMIT: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = SQ_IDLE;
            end
         end

         default: state_in = SQ_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_in       = push_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SQ_IDLE;
         now_ff        <= '0;
         qhead_ff      <= EMPTY_MARK;
         fhead_ff      <= '0;
         count_ff      <= '0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         qhead_ff      <= qhead_in;
         fhead_ff      <= fhead_in;
         count_ff      <= count_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      key_ff  <= key_in;
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      node_ff <= node_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PTR_W'(QUEUE_DEPTH))
      else $error("queue count beyond pool size");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (qhead_ff == EMPTY_MARK) == (count_ff == '0))
      else $error("queue head and count disagree");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.action == ACT_TICK
      |=> now_ff == $past(now_ff) + TIME_W'(1))
      else $error("tick did not advance counter by one");

   a_release_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= CNT_W'(MAX_RESULTS))
      else $error("too many releases in one tick");

   a_no_push_on_full: assert property (@(posedge clock) disable iff (reset)
      push && rsp_valid_ff |-> rsp_ready)
      else $error("result overwritten while stalled");

endmodule
